FILE: src/mvt_pkg.sv
package mvt_pkg;

  localparam int DIM      = 4;
  localparam int LAST_IDX = 3;
  localparam int IDX_W    = $clog2(DIM);

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_XFORM = 1'b1
  } mode_e;

  // load strobes of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_ld_t;

endpackage

FILE: src/mvt_if.sv
interface mvt_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mvt_pkg::IDX_W-1:0]     row;
  logic [mvt_pkg::IDX_W-1:0]     col;
  logic signed [VALUE_WIDTH-1:0] value;
  logic signed [VALUE_WIDTH-1:0] x;
  logic signed [VALUE_WIDTH-1:0] y;
  logic signed [VALUE_WIDTH-1:0] z;
  logic signed [VALUE_WIDTH-1:0] w;

  modport source (output valid, mode, row, col, value, x, y, z, w, input ready);
  modport sink   (input valid, mode, row, col, value, x, y, z, w, output ready);
endinterface

interface mvt_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] out_x;
  logic signed [VALUE_WIDTH-1:0] out_y;
  logic signed [VALUE_WIDTH-1:0] out_z;
  logic signed [VALUE_WIDTH-1:0] out_w;
  logic                          saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

FILE: src/mvt_matrix.sv
module mvt_matrix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [mvt_pkg::IDX_W-1:0]     row_i,
  input  logic [mvt_pkg::IDX_W-1:0]     col_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic signed [VALUE_WIDTH-1:0] mat_o [mvt_pkg::DIM][mvt_pkg::DIM]
);

  logic signed [VALUE_WIDTH-1:0] mat_q [mvt_pkg::DIM][mvt_pkg::DIM];

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
    for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_col
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mat_q[r][c] <= '0;
        end else if (we_i && row_i == mvt_pkg::IDX_W'(r) && col_i == mvt_pkg::IDX_W'(c)) begin
          mat_q[r][c] <= value_i;
        end
      end
      assign mat_o[r][c] = mat_q[r][c];
    end
  end

endmodule

FILE: src/mvt_mult.sv
module mvt_mult #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  mvt_pkg::pipe_ld_t               ld_i,
  input  logic signed [VALUE_WIDTH-1:0]   mat_i  [mvt_pkg::DIM][mvt_pkg::DIM],
  input  logic signed [VALUE_WIDTH-1:0]   vec_i  [mvt_pkg::DIM],
  output logic signed [2*VALUE_WIDTH-1:0] prod_o [mvt_pkg::DIM][mvt_pkg::DIM]
);

  localparam int LO_W = VALUE_WIDTH / 2;
  localparam int HI_W = VALUE_WIDTH - LO_W;
  localparam int PW   = 2 * VALUE_WIDTH;

  // split operands: signed high half, unsigned low half
  logic signed [2*HI_W-1:0]    hh_q   [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [VALUE_WIDTH:0] hl_q   [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [VALUE_WIDTH:0] lh_q   [mvt_pkg::DIM][mvt_pkg::DIM];
  logic [2*LO_W-1:0]           ll_q   [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [PW-1:0]        prod_q [mvt_pkg::DIM][mvt_pkg::DIM];

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
    for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_col
      logic signed [HI_W-1:0] a_hi;
      logic signed [HI_W-1:0] b_hi;
      logic signed [LO_W:0]   a_lo;
      logic signed [LO_W:0]   b_lo;
      logic signed [PW-1:0]   hh_x;
      logic signed [PW-1:0]   mid_x;
      logic signed [PW-1:0]   ll_x;

      assign a_hi = mat_i[r][c][VALUE_WIDTH-1:LO_W];
      assign b_hi = vec_i[c][VALUE_WIDTH-1:LO_W];
      assign a_lo = {1'b0, mat_i[r][c][LO_W-1:0]};
      assign b_lo = {1'b0, vec_i[c][LO_W-1:0]};

      always_ff @(posedge clk_i) begin
        if (ld_i.s1) begin
          hh_q[r][c] <= a_hi * b_hi;
          hl_q[r][c] <= a_hi * b_lo;
          lh_q[r][c] <= a_lo * b_hi;
          ll_q[r][c] <= a_lo[LO_W-1:0] * b_lo[LO_W-1:0];
        end
      end

      assign hh_x  = {hh_q[r][c], {(2*LO_W){1'b0}}};
      assign mid_x = (PW'(hl_q[r][c]) + PW'(lh_q[r][c])) <<< LO_W;
      assign ll_x  = PW'(ll_q[r][c]);

      always_ff @(posedge clk_i) begin
        if (ld_i.s2) begin
          prod_q[r][c] <= hh_x + mid_x + ll_x;
        end
      end

      assign prod_o[r][c] = prod_q[r][c];
    end
  end

endmodule

FILE: src/mvt_reduce.sv
module mvt_reduce #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  mvt_pkg::pipe_ld_t               ld_i,
  input  logic signed [2*VALUE_WIDTH-1:0] prod_i [mvt_pkg::DIM][mvt_pkg::DIM],
  output logic signed [VALUE_WIDTH-1:0]   res_o  [mvt_pkg::DIM],
  output logic                            sat_o
);

  localparam int SW = 2 * VALUE_WIDTH + 2;

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [SW-1:0]          sum_q [mvt_pkg::DIM];
  logic signed [VALUE_WIDTH-1:0] res_q [mvt_pkg::DIM];
  logic [mvt_pkg::DIM-1:0]       ovf;
  logic                          sat_q;

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
    logic signed [SW-1:0]          sh;
    logic [SW-VALUE_WIDTH:0]       top;
    logic signed [VALUE_WIDTH-1:0] res_d;

    always_ff @(posedge clk_i) begin
      if (ld_i.s3) begin
        sum_q[r] <= SW'(prod_i[r][0]) + SW'(prod_i[r][1])
                  + SW'(prod_i[r][2]) + SW'(prod_i[r][mvt_pkg::LAST_IDX]);
      end
    end

    assign sh     = sum_q[r] >>> FRAC_BITS;
    assign top    = sh[SW-1:VALUE_WIDTH-1];
    assign ovf[r] = !((&top) || !(|top));
    assign res_d  = ovf[r] ? (sh[SW-1] ? VMIN : VMAX) : sh[VALUE_WIDTH-1:0];

    always_ff @(posedge clk_i) begin
      if (ld_i.s4) begin
        res_q[r] <= res_d;
      end
    end

    assign res_o[r] = res_q[r];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      sat_q <= |ovf;
    end
  end

  assign sat_o = sat_q;

endmodule

FILE: src/matrix_vector_transform.sv
// Channel | Dir | Handshake   | Payload
// in_i    | in  | valid/ready | mode, row, col, value, x, y, z, w
// out_o   | out | valid/ready | out_x, out_y, out_z, out_w, saturated
//
// One item per cycle unless in_i.ready drops under an output stall. A transform item's
// result passes, once accepted, through partial products, product assembly, row sum, shift/saturate.
// A write item updates the matrix at once and produces nothing.
// Reset clears the matrix and all stage valid bits.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// collapse under an output stall; in_i.ready drops only with all stages full.
module matrix_vector_transform #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mvt_in_if.sink   in_i,
  mvt_out_if.source out_o
);

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [VALUE_WIDTH-1:0]   mat  [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [VALUE_WIDTH-1:0]   vec  [mvt_pkg::DIM];
  logic signed [2*VALUE_WIDTH-1:0] prod [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [VALUE_WIDTH-1:0]   res  [mvt_pkg::DIM];
  logic                            sat;

  mvt_pkg::pipe_ld_t ld;
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic is_xform;
  logic mat_we;

  assign is_xform = (in_i.mode == mvt_pkg::MODE_XFORM);

  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld.s1 = rdy1 && in_i.valid && is_xform;
  assign ld.s2 = rdy2 && v1_q;
  assign ld.s3 = rdy3 && v2_q;
  assign ld.s4 = rdy4 && v3_q;

  assign v1_d = rdy1 ? (in_i.valid && is_xform) : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  assign mat_we     = in_i.valid && rdy1 && (in_i.mode == mvt_pkg::MODE_WRITE);
  assign in_i.ready = rdy1;

  assign vec[0] = in_i.x;
  assign vec[1] = in_i.y;
  assign vec[2] = in_i.z;
  assign vec[mvt_pkg::LAST_IDX] = in_i.w;

  mvt_matrix #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mat_we),
    .row_i   (in_i.row),
    .col_i   (in_i.col),
    .value_i (in_i.value),
    .mat_o   (mat)
  );

  mvt_mult #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mult (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .mat_i  (mat),
    .vec_i  (vec),
    .prod_o (prod)
  );

  mvt_reduce #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_reduce (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .prod_i (prod),
    .res_o  (res),
    .sat_o  (sat)
  );

  assign out_o.valid     = v4_q;
  assign out_o.out_x     = res[0];
  assign out_o.out_y     = res[1];
  assign out_o.out_z     = res[2];
  assign out_o.out_w     = res[mvt_pkg::LAST_IDX];
  assign out_o.saturated = sat;

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode == mvt_pkg::MODE_WRITE) |=> !v1_q)
    else $error("write item entered the pipeline");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a free stage");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.out_x == VMAX || out_o.out_x == VMIN ||
       out_o.out_y == VMAX || out_o.out_y == VMIN ||
       out_o.out_z == VMAX || out_o.out_z == VMIN ||
       out_o.out_w == VMAX || out_o.out_w == VMIN))
    else $error("saturated flag without a clipped component");

endmodule
